[hdl/hemd_pkg.sv]
// Package for the one-dimensional earth mover's distance block.
// Holds field widths, item and status codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package hemd_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 256;

  localparam int KIND_W = 2;
  localparam int POS_W  = 16;
  localparam int WT_W   = 24;
  localparam int DIST_W = 64;
  localparam int STAT_W = 2;
  localparam int PROD_W = WT_W + POS_W;

  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic rd_init;
    logic load_both;
    logic calc;
    logic accum;
    logic load_next;
    logic finish;
  } hemd_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } hemd_stat_t;

endpackage

[hdl/hemd_if.sv]
// Valid/ready channel interfaces for the request and result streams.
// Depends on hemd_pkg for the field widths.
`timescale 1ns / 1ps

interface hemd_in_if;
  import hemd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [POS_W-1:0]     entry_position;
  logic [WT_W-1:0]      entry_weight;

  modport source (output valid, kind, entry_position, entry_weight, input ready);
  modport sink (input valid, kind, entry_position, entry_weight, output ready);
endinterface

interface hemd_out_if;
  import hemd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DIST_W-1:0]    distance;
  logic [STAT_W-1:0]    status;

  modport source (output valid, distance, status, input ready);
  modport sink (input valid, distance, status, output ready);
endinterface

[hdl/hemd_ctrl.sv]
// Controller state machine: accepts requests, sequences the merge walk and
// drives the result valid. Depends on hemd_pkg.
`timescale 1ns / 1ps

module hemd_ctrl
  import hemd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  output logic              out_valid,
  input  logic              out_ready,
  input  hemd_stat_t        stat,
  output hemd_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_LOAD_A: cmd.wr_a = 1'b1;
            KIND_LOAD_B: cmd.wr_b = 1'b1;
            KIND_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = stat.empty ? S_DONE : S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.rd_init = 1'b1;
        state_nxt   = S_PRIME;
      end
      S_PRIME: begin
        cmd.load_both = 1'b1;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.accum = 1'b1;
        if (stat.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.load_next = 1'b1;
          state_nxt     = S_CALC;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/hemd_dp.sv]
// Datapath: histogram entry memories, counts, walk pointers, remaining
// weights, gap multiplier, saturating sum and result register. Depends on hemd_pkg.
`timescale 1ns / 1ps

module hemd_dp
  import hemd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  hemd_cmd_t         cmd,
  output hemd_stat_t        stat,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WT_W-1:0]   in_weight,
  output logic [DIST_W-1:0] out_distance,
  output logic [STAT_W-1:0] out_status
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = POS_W + WT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic [ENT_W-1:0] mem_a [MAX_ENTRIES];
  logic [ENT_W-1:0] mem_b [MAX_ENTRIES];
  logic [ENT_W-1:0] rd_a_r, rd_b_r;

  logic [CNT_W-1:0] a_count_r, a_count_nxt, b_count_r, b_count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] i_inc, j_inc;
  logic [IDX_W-1:0] a_raddr, b_raddr;
  logic             a_full, b_full;

  logic [WT_W-1:0]   rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [POS_W-1:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              took_a_r, took_a_nxt;
  logic              last_r, last_nxt;
  logic [DIST_W-1:0] sum_r, sum_nxt;
  logic [DIST_W:0]   sum_ext;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic              take_a;
  logic [WT_W-1:0]   rem_min;
  logic [POS_W-1:0]  gap;

  assign a_full  = (a_count_r == CNT_MAX);
  assign b_full  = (b_count_r == CNT_MAX);
  assign i_inc   = i_r + CNT_W'(1);
  assign j_inc   = j_r + CNT_W'(1);
  assign a_raddr = cmd.rd_init ? i_r[IDX_W-1:0] : i_inc[IDX_W-1:0];
  assign b_raddr = cmd.rd_init ? j_r[IDX_W-1:0] : j_inc[IDX_W-1:0];

  assign take_a  = (rem_a_r <= rem_b_r);
  assign rem_min = take_a ? rem_a_r : rem_b_r;
  assign gap     = (pa_r > pb_r) ? (pa_r - pb_r) : (pb_r - pa_r);
  assign sum_ext = {1'b0, sum_r} + {{(DIST_W + 1 - PROD_W){1'b0}}, prod_r};

  assign stat.empty   = (a_count_r == '0) || (b_count_r == '0);
  assign stat.last    = last_r;
  assign out_distance = dist_r;
  assign out_status   = status_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_a && !a_full) begin
      mem_a[a_count_r[IDX_W-1:0]] <= {in_position, in_weight};
    end
    if (cmd.wr_b && !b_full) begin
      mem_b[b_count_r[IDX_W-1:0]] <= {in_position, in_weight};
    end
    rd_a_r <= mem_a[a_raddr];
    rd_b_r <= mem_b[b_raddr];
  end

  always_comb begin
    a_count_nxt = a_count_r;
    b_count_nxt = b_count_r;
    ovf_nxt     = ovf_r;
    if (cmd.wr_a) begin
      if (a_full) begin
        ovf_nxt = 1'b1;
      end else begin
        a_count_nxt = a_count_r + CNT_W'(1);
      end
    end
    if (cmd.wr_b) begin
      if (b_full) begin
        ovf_nxt = 1'b1;
      end else begin
        b_count_nxt = b_count_r + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      a_count_nxt = '0;
      b_count_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_comb begin
    i_nxt      = i_r;
    j_nxt      = j_r;
    rem_a_nxt  = rem_a_r;
    rem_b_nxt  = rem_b_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    prod_nxt   = prod_r;
    took_a_nxt = took_a_r;
    last_nxt   = last_r;
    sum_nxt    = sum_r;
    dist_nxt   = dist_r;
    status_nxt = status_r;
    if (cmd.start) begin
      i_nxt   = '0;
      j_nxt   = '0;
      sum_nxt = '0;
    end
    if (cmd.load_both) begin
      {pa_nxt, rem_a_nxt} = rd_a_r;
      {pb_nxt, rem_b_nxt} = rd_b_r;
    end
    if (cmd.calc) begin
      prod_nxt   = PROD_W'(rem_min) * PROD_W'(gap);
      took_a_nxt = take_a;
      if (take_a) begin
        rem_b_nxt = rem_b_r - rem_a_r;
        i_nxt     = i_inc;
        last_nxt  = (i_inc >= a_count_r);
      end else begin
        rem_a_nxt = rem_a_r - rem_b_r;
        j_nxt     = j_inc;
        last_nxt  = (j_inc >= b_count_r);
      end
    end
    if (cmd.accum) begin
      sum_nxt = sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
    end
    if (cmd.load_next) begin
      if (took_a_r) begin
        {pa_nxt, rem_a_nxt} = rd_a_r;
      end else begin
        {pb_nxt, rem_b_nxt} = rd_b_r;
      end
    end
    if (cmd.finish) begin
      if (stat.empty) begin
        dist_nxt   = '0;
        status_nxt = STATUS_EMPTY;
      end else begin
        dist_nxt   = sum_r;
        status_nxt = ovf_r ? STATUS_OVERFLOW : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_count_r <= '0;
      b_count_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      a_count_r <= a_count_nxt;
      b_count_r <= b_count_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    rem_a_r  <= rem_a_nxt;
    rem_b_r  <= rem_b_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    prod_r   <= prod_nxt;
    took_a_r <= took_a_nxt;
    last_r   <= last_nxt;
    sum_r    <= sum_nxt;
    dist_r   <= dist_nxt;
    status_r <= status_nxt;
  end

endmodule

[hdl/histogram_emd_1d_top.sv]
// Load requests are accepted whenever the controller is idle. A compute request walks S
// merge steps, where S <= a_count + b_count - 1; each step is a multiply state (S_CALC)
// followed by a memory fetch and accumulate state (S_FETCH). An empty histogram skips the
// walk and goes straight to its result. Requests are held off while a compute runs.
// Synchronous active-low reset clears the counts, the overflow flag and the control state.
// Depends on hemd_pkg, hemd_if, hemd_ctrl and hemd_dp.
`timescale 1ns / 1ps

module histogram_emd_1d_top
  import hemd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
  input  logic   clk,
  input  logic   rst_n,
  hemd_in_if.sink    in_ch,
  hemd_out_if.source out_ch
);

  hemd_cmd_t  cmd;
  hemd_stat_t stat;

  hemd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hemd_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_position  (in_ch.entry_position),
    .in_weight    (in_ch.entry_weight),
    .out_distance (out_ch.distance),
    .out_status   (out_ch.status)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for histogram_emd_1d_top: directed table, then random histogram sets.
// Expected distances come from an in-bench merge-walk predictor or from fixed values in the directed table;
// both channels idle at random. Depends on hemd_pkg, hemd_if and the top level of the block.
`timescale 1ns / 1ps

module testbench;
  import hemd_pkg::*;

  localparam int MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
  localparam int RANDOM_ITEMS = 1700;
  localparam int BIG_SET_AT = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [WT_W-1:0]   wt;
    bit                fixed;
    logic [DIST_W-1:0] fixed_dist;
    logic [STAT_W-1:0] fixed_status;
  } request_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [STAT_W-1:0] status;
  } distance_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hemd_in_if  in_ch();
  hemd_out_if out_ch();

  histogram_emd_1d_top #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  logic [POS_W-1:0] hist_a_pos [MAX_ENTRIES];
  logic [WT_W-1:0]  hist_a_wt  [MAX_ENTRIES];
  logic [POS_W-1:0] hist_b_pos [MAX_ENTRIES];
  logic [WT_W-1:0]  hist_b_wt  [MAX_ENTRIES];
  int unsigned      hist_a_count;
  int unsigned      hist_b_count;
  bit               dropped_load;

  request_t         request_q [$];
  distance_result_t pending_distances [$];

  int unsigned cycle_count = 0;
  int unsigned failures = 0;
  int unsigned queued_items = 0;
  int unsigned load_count = 0;
  int unsigned compute_count = 0;
  int unsigned reserved_count = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_results = 0;
  int unsigned empty_results = 0;
  int unsigned stall_mode = 0;

  request_t directed_reqs [22] = '{
    '{KIND_COMPUTE,  16'h0000, 24'h000000, 1'b1, 64'h0, STATUS_EMPTY},
    '{KIND_LOAD_A,   16'h0000, 24'h000000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'h0000, 24'h000000, 1'b1, 64'h0, STATUS_EMPTY},
    '{KIND_LOAD_B,   16'hFFFF, 24'hFFFFFF, 1'b0, 64'h0, STATUS_OK},
    '{KIND_RESERVED, 16'h1234, 24'h567890, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'hFFFF, 24'hFFFFFF, 1'b1, 64'h0, STATUS_EMPTY},
    '{KIND_LOAD_A,   16'h0000, 24'hFFFFFF, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'hFFFF, 24'hFFFFFF, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'h0000, 24'h000000, 1'b1, 64'h0000_00FF_FEFF_0001, STATUS_OK},
    '{KIND_LOAD_A,   16'hFFFF, 24'h000000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'h0000, 24'h000000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'h0000, 24'h000000, 1'b1, 64'h0, STATUS_OK},
    '{KIND_LOAD_A,   16'd100,  24'h030000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_A,   16'd10,   24'h010000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'd50,   24'h018000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'd5,    24'h028000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_RESERVED, 16'hFFFF, 24'hFFFFFF, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'h0000, 24'h000000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_A,   16'h8000, 24'h800000, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'h7FFF, 24'h7FFFFF, 1'b0, 64'h0, STATUS_OK},
    '{KIND_LOAD_B,   16'h8001, 24'h000001, 1'b0, 64'h0, STATUS_OK},
    '{KIND_COMPUTE,  16'h5555, 24'hAAAAAA, 1'b0, 64'h0, STATUS_OK}
  };

  function automatic logic [DIST_W-1:0] predict_distance();
    int unsigned i = 0;
    int unsigned j = 0;
    bit took_b;
    logic [POS_W-1:0] diff;
    logic [DIST_W-1:0] rem_a, rem_b, gap, step, sum;
    logic [DIST_W:0] total;
    rem_a = DIST_W'(hist_a_wt[0]);
    rem_b = DIST_W'(hist_b_wt[0]);
    sum = '0;
    while (1'b1) begin
      diff = (hist_a_pos[i] > hist_b_pos[j]) ? hist_a_pos[i] - hist_b_pos[j]
                                             : hist_b_pos[j] - hist_a_pos[i];
      gap = DIST_W'(diff);
      took_b = rem_a > rem_b;
      if (took_b) begin
        rem_a = rem_a - rem_b;
        step = rem_b * gap;
        j++;
      end else begin
        rem_b = rem_b - rem_a;
        step = rem_a * gap;
        i++;
      end
      total = {1'b0, sum} + {1'b0, step};
      sum = total[DIST_W] ? '1 : total[DIST_W-1:0];
      if (i >= hist_a_count || j >= hist_b_count) return sum;
      if (took_b) rem_b = DIST_W'(hist_b_wt[j]);
      else rem_a = DIST_W'(hist_a_wt[i]);
    end
    return sum;
  endfunction

  task automatic apply_request(input request_t req);
    distance_result_t res;
    case (req.kind)
      KIND_LOAD_A: begin
        load_count++;
        if (hist_a_count < MAX_ENTRIES) begin
          hist_a_pos[hist_a_count] = req.pos;
          hist_a_wt[hist_a_count] = req.wt;
          hist_a_count++;
        end else begin
          dropped_load = 1'b1;
        end
      end
      KIND_LOAD_B: begin
        load_count++;
        if (hist_b_count < MAX_ENTRIES) begin
          hist_b_pos[hist_b_count] = req.pos;
          hist_b_wt[hist_b_count] = req.wt;
          hist_b_count++;
        end else begin
          dropped_load = 1'b1;
        end
      end
      KIND_COMPUTE: begin
        compute_count++;
        if (hist_a_count == 0 || hist_b_count == 0) begin
          res.distance = '0;
          res.status = STATUS_EMPTY;
          empty_results++;
        end else begin
          res.distance = predict_distance();
          res.status = dropped_load ? STATUS_OVERFLOW : STATUS_OK;
          if (dropped_load) overflow_results++;
        end
        if (req.fixed) begin
          res.distance = req.fixed_dist;
          res.status = req.fixed_status;
        end
        pending_distances.push_back(res);
        hist_a_count = 0;
        hist_b_count = 0;
        dropped_load = 1'b0;
      end
      default: reserved_count++;
    endcase
  endtask

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [WT_W-1:0] wt);
    request_t req;
    req.kind = kind;
    req.pos = pos;
    req.wt = wt;
    req.fixed = 1'b0;
    req.fixed_dist = '0;
    req.fixed_status = STATUS_OK;
    request_q.push_back(req);
    if (kind != KIND_RESERVED) queued_items++;
  endtask

  function automatic logic [WT_W-1:0] pick_weight(input int unsigned mode,
                                                  input logic [WT_W-1:0] shared);
    case (mode)
      0: return WT_W'($urandom);
      1: return WT_W'($urandom_range(0, 255));
      2: return {8'($urandom_range(0, 255)), 16'h0000};
      3: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: return shared;
    endcase
  endfunction

  task automatic build_random_requests();
    int unsigned choice, n_a, n_b, ia, ib, wmode, k, n, big_done;
    bit sorted;
    logic [WT_W-1:0] shared;
    logic [POS_W-1:0] pos_a [$];
    logic [POS_W-1:0] pos_b [$];
    logic [WT_W-1:0] wt_a [$];
    logic [WT_W-1:0] wt_b [$];
    int unsigned next_pos;
    big_done = 0;
    while (queued_items < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      pos_a.delete();
      pos_b.delete();
      wt_a.delete();
      wt_b.delete();
      if (big_done == 0 && queued_items > BIG_SET_AT) begin
        big_done = 1;
        n_a = MAX_ENTRIES + 2;
        n_b = MAX_ENTRIES + 1;
        wmode = 0;
        sorted = 1'b1;
      end else if (choice < 6) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) queue_request(KIND_RESERVED, POS_W'($urandom), WT_W'($urandom));
        queue_request(KIND_COMPUTE, POS_W'($urandom), WT_W'($urandom));
        continue;
      end else if (choice < 12) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          queue_request(($urandom_range(0, 1) == 0) ? KIND_LOAD_A : KIND_LOAD_B,
                        POS_W'($urandom), WT_W'($urandom));
        end
        queue_request(KIND_COMPUTE, POS_W'($urandom), WT_W'($urandom));
        continue;
      end else begin
        choice = $urandom_range(0, 9);
        n_a = (choice < 7) ? $urandom_range(1, 6) : (choice < 9) ? $urandom_range(7, 20)
                                                                 : $urandom_range(21, 60);
        choice = $urandom_range(0, 9);
        n_b = (choice < 7) ? $urandom_range(1, 6) : (choice < 9) ? $urandom_range(7, 20)
                                                                 : $urandom_range(21, 60);
        wmode = $urandom_range(0, 4);
        sorted = ($urandom_range(0, 4) != 0);
      end
      shared = pick_weight(0, '0);
      next_pos = $urandom_range(0, 32767);
      for (k = 0; k < n_a; k++) begin
        if (sorted) begin
          pos_a.push_back(POS_W'(next_pos));
          next_pos = next_pos + $urandom_range(0, 600);
          if (next_pos > 65535) next_pos = 65535;
        end else begin
          pos_a.push_back(POS_W'($urandom));
        end
        wt_a.push_back(pick_weight(wmode, shared));
      end
      next_pos = $urandom_range(0, 32767);
      for (k = 0; k < n_b; k++) begin
        if (sorted) begin
          pos_b.push_back(POS_W'(next_pos));
          next_pos = next_pos + $urandom_range(0, 600);
          if (next_pos > 65535) next_pos = 65535;
        end else begin
          pos_b.push_back(POS_W'($urandom));
        end
        wt_b.push_back(pick_weight(wmode, shared));
      end
      ia = 0;
      ib = 0;
      while (ia < n_a || ib < n_b) begin
        if ($urandom_range(0, 39) == 0) begin
          queue_request(KIND_RESERVED, POS_W'($urandom), WT_W'($urandom));
        end
        if (ib >= n_b || (ia < n_a && $urandom_range(0, 1) == 0)) begin
          queue_request(KIND_LOAD_A, pos_a[ia], wt_a[ia]);
          ia++;
        end else begin
          queue_request(KIND_LOAD_B, pos_b[ib], wt_b[ib]);
          ib++;
        end
      end
      queue_request(KIND_COMPUTE, POS_W'($urandom), WT_W'($urandom));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    distance_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_distances.size() == 0) begin
        $error("unexpected result: distance %h status %0d", out_ch.distance, out_ch.status);
        failures++;
      end else begin
        exp_res = pending_distances.pop_front();
        results_checked++;
        if (out_ch.distance !== exp_res.distance) begin
          $error("distance: expected %h, actual %h", exp_res.distance, out_ch.distance);
          failures++;
        end
        if (out_ch.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_ch.status);
          failures++;
        end
      end
    end
    if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 0);
      2: out_ch.ready <= (cycle_count % 4 != 0);
      default: out_ch.ready <= ((cycle_count / 8) % 4 == 0);
    endcase
  end

  initial begin
    request_t cur;
    bit holding;
    int unsigned burst_left, gap_left, k;
    holding = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_LOAD_A;
    in_ch.entry_position <= '0;
    in_ch.entry_weight <= '0;
    hist_a_count = 0;
    hist_b_count = 0;
    dropped_load = 1'b0;

    for (k = 0; k < 22; k++) request_q.push_back(directed_reqs[k]);
    build_random_requests();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        apply_request(cur);
        holding = 1'b0;
      end
      if (!holding && request_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        break;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          cur = request_q.pop_front();
          holding = 1'b1;
          in_ch.kind <= cur.kind;
          in_ch.entry_position <= cur.pos;
          in_ch.entry_weight <= cur.wt;
          in_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end

    while (pending_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d computes and %0d reserved requests.",
             load_count, compute_count, reserved_count);
    $display("Compared %0d results: %0d with an empty histogram, %0d with dropped loads.",
             results_checked, empty_results, overflow_results);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
